// ===== rtl/bitmap_slot_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define BSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, transaction types, codes and the lowest-free-bit encoder.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Pool geometry
  localparam int BITS_PER_WORD = 16;
  localparam int NUM_WORDS     = 64;
  localparam int CAPACITY      = NUM_WORDS * BITS_PER_WORD;

  // Derived widths
  localparam int BIT_W   = $clog2(BITS_PER_WORD);
  localparam int WORD_AW = $clog2(NUM_WORDS);
  localparam int IDX_W   = WORD_AW + BIT_W;
  localparam int CNT_W   = WORD_AW + 1;
  localparam int HW_W    = IDX_W + 1;

  // All slots of a word free
  localparam logic [BITS_PER_WORD-1:0] WORD_MASK = '1;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] free_index;
  } bsa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic             fresh;
    logic [1:0]       status;
  } bsa_out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RDSTK,
    S_RDWORD,
    S_EXEC
  } bsa_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_stack;
    logic rd_word;
    logic exec;
  } bsa_cmd_t;

  // Position of the lowest set bit
  function automatic logic [BIT_W-1:0] lowest_set(input logic [BITS_PER_WORD-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (v[i]) n = BIT_W'(i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences each transaction: stack read, bitmap read, update.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output bsa_pkg::bsa_cmd_t cmd_o
);

  bsa_pkg::bsa_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the fixed sequence
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      bsa_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = bsa_pkg::S_RDSTK;
        end
      end
      bsa_pkg::S_RDSTK: begin
        cmd_o.rd_stack = 1'b1;
        state_d        = bsa_pkg::S_RDWORD;
      end
      bsa_pkg::S_RDWORD: begin
        cmd_o.rd_word = 1'b1;
        state_d       = bsa_pkg::S_EXEC;
      end
      bsa_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = bsa_pkg::S_IDLE;
      end
      default: begin
        state_d = bsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bsa_datapath.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Free-bit memory, open-word stack, counters and the result register.
// ----------------------------------------------------------------------------
module bsa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsa_pkg::bsa_cmd_t cmd_i,
  input  bsa_pkg::bsa_in_t  req_i,
  output logic              done_o,
  output bsa_pkg::bsa_out_t result_o
);

  localparam int BPW = bsa_pkg::BITS_PER_WORD;
  localparam int WAW = bsa_pkg::WORD_AW;
  localparam int BW  = bsa_pkg::BIT_W;
  localparam int CW  = bsa_pkg::CNT_W;
  localparam int HW  = bsa_pkg::HW_W;
  localparam int IW  = bsa_pkg::IDX_W;

  // Storage
  logic [BPW-1:0] bm_mem  [bsa_pkg::NUM_WORDS];
  logic [WAW-1:0] stk_mem [bsa_pkg::NUM_WORDS];

  bsa_pkg::bsa_in_t  req_q;
  bsa_pkg::bsa_out_t res_q, res_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [HW-1:0]     hw_q, hw_d;
  logic [WAW-1:0]    top_word_q;
  logic [BPW-1:0]    bits_q;

  // Memory port controls
  logic           stk_re, bm_re, stk_we, bm_we;
  logic [WAW-1:0] stk_raddr, bm_raddr, stk_waddr, bm_waddr;
  logic [WAW-1:0] stk_wdata;
  logic [BPW-1:0] bm_wdata;

  // Update-stage helpers
  logic           is_alloc, top_ok, alloc_hit, hw_full, in_range;
  logic [BW-1:0]  low_bit;
  logic [BPW-1:0] low_onehot, cleared, open_onehot, free_onehot;
  logic [HW-1:0]  hit_slot;
  logic [CW-1:0]  cnt_m1, cnt_pop;
  logic [WAW-1:0] free_word, open_word;

  assign is_alloc  = (req_q.opcode == bsa_pkg::OP_ALLOC);
  assign top_ok    = (cnt_q != '0);
  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_pop   = cnt_q - CW'(top_ok);
  assign free_word = req_q.free_index[BW +: WAW];
  assign open_word = hw_q[BW +: WAW];
  assign in_range  = (HW'(req_q.free_index) < hw_q);
  assign hw_full   = (hw_q >= HW'(bsa_pkg::CAPACITY));

  assign low_bit     = bsa_pkg::lowest_set(bits_q);
  assign low_onehot  = BPW'(1) << low_bit;
  assign cleared     = bits_q & ~low_onehot;
  assign alloc_hit   = top_ok && (bits_q != '0);
  assign hit_slot    = HW'({top_word_q, low_bit});
  assign open_onehot = BPW'(1) << hw_q[BW-1:0];
  assign free_onehot = BPW'(1) << req_q.free_index[BW-1:0];

  // Read ports
  assign stk_re    = cmd_i.rd_stack && top_ok;
  assign stk_raddr = cnt_m1[WAW-1:0];
  assign bm_re     = cmd_i.rd_word && (is_alloc ? top_ok : in_range);
  assign bm_raddr  = is_alloc ? top_word_q : free_word;

  // Hold the request for the whole transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      top_word_q <= stk_mem[stk_raddr];
    end
  end

  // Free-bit memory
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bits_q <= bm_mem[bm_raddr];
    end
  end

  // Update stage: allocate or release, then build the result
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = cnt_q[WAW-1:0];
    stk_wdata = free_word;
    bm_we     = 1'b0;
    bm_waddr  = free_word;
    bm_wdata  = bits_q | free_onehot;
    cnt_d     = cnt_q;
    hw_d      = hw_q;
    res_d     = res_q;
    done_d    = 1'b0;
    if (cmd_i.exec) begin
      done_d = 1'b1;
      res_d  = '0;
      if (is_alloc) begin
        if (alloc_hit) begin
          // take the lowest free slot of the top word
          bm_we            = 1'b1;
          bm_waddr         = top_word_q;
          bm_wdata         = cleared;
          res_d.slot_index = hit_slot[IW-1:0];
          if (cleared == '0) begin
            cnt_d = cnt_m1;
          end
          if (hit_slot >= hw_q) begin
            res_d.fresh = 1'b1;
            hw_d        = hit_slot + HW'(1);
          end
        end else begin
          // drop a full top word, then open a new word at the mark
          cnt_d = cnt_pop;
          if (hw_full) begin
            res_d.status = bsa_pkg::ST_FULL;
          end else begin
            bm_we    = 1'b1;
            bm_waddr = open_word;
            bm_wdata = bsa_pkg::WORD_MASK & ~open_onehot;
            if (cnt_pop < CW'(bsa_pkg::NUM_WORDS)) begin
              stk_we    = 1'b1;
              stk_waddr = cnt_pop[WAW-1:0];
              stk_wdata = open_word;
              cnt_d     = cnt_pop + CW'(1);
            end
            res_d.slot_index = hw_q[IW-1:0];
            res_d.fresh      = 1'b1;
            hw_d             = hw_q + HW'(1);
          end
        end
      end else begin
        res_d.slot_index = req_q.free_index;
        if (!in_range) begin
          res_d.status = bsa_pkg::ST_RANGE;
        end else begin
          // set the slot bit, push the word if it was full and the stack has room
          bm_we = 1'b1;
          if ((bits_q == '0) && (cnt_q < CW'(bsa_pkg::NUM_WORDS))) begin
            stk_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hw_q   <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      hw_q   <= hw_d;
      done_q <= done_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Fixed-slot allocator over a free-bit map with a stack of open words.
// ----------------------------------------------------------------------------
// A transaction is accepted when start_i is high and busy_o is low. In each
// transaction the top of the open-word stack is read, then the free-bit word
// it names (or the word of the slot being released), then the bitmap, stack
// and high-water mark are updated. Because of these two dependent registered
// memory reads, a new transaction is accepted only after the last is updated.
// The result appears on result_o with done_o high for exactly one cycle, and
// cannot be held off by the receiver; busy_o is already low in that cycle,
// so the next transaction may start alongside it. Both memories are undefined
// after reset and need no clearing pass.
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bsa_pkg::bsa_in_t  cmd_i,
  output logic              busy_o,
  output logic              done_o,
  output bsa_pkg::bsa_out_t result_o
);

  bsa_pkg::bsa_cmd_t cmd;

  // Sequencer
  bsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Storage and update logic
  bsa_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Checks
  `BSA_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted transaction did not raise busy")
  `BSA_ASSERT_IMPL(a_done_after_busy, done_o, $past(busy_o), "result strobe without a running transaction")
  `BSA_ASSERT_IMPL(a_full_quiet, done_o && (result_o.status == bsa_pkg::ST_FULL), (result_o.slot_index == '0) && !result_o.fresh, "pool-full result carries a slot")
  `BSA_ASSERT_IMPL(a_fresh_ok, done_o && result_o.fresh, result_o.status == bsa_pkg::ST_OK, "fresh slot reported with error status")

endmodule
